// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds on the next clock.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- design/ial_pkg.sv -----
`timescale 1ns / 1ps

package ial_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;
    localparam int POS_W        = 5;
    localparam int STS_W        = 2;
    localparam int CNT_OUT_W    = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take the accepted input beat
        logic rd_pos;     // read the store at the requested position
        logic rd_src;     // read the next shift source
        logic wr_shift;   // write the shifted entry and step the index
        logic wr_val;     // write the input value at the requested position
        logic cap_result; // capture read data as the result value
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;   // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            err;
        logic [OP_W-1:0] op;
        logic            idx_at_pos;
        logic            prev_at_pos;
        logic            has_next;
        logic            has_next2;
        logic            out_free;
    } t_dp_sts;

endpackage

// ----- design/ial_ctrl.sv -----
`timescale 1ns / 1ps

module ial_ctrl import ial_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.err) begin
                    n_state = S_FINISH;
                end else begin
                    case (i_sts.op)
                        OP_GET, OP_REMOVE: begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = S_READ;
                        end
                        OP_SET: begin
                            o_cmd.wr_val = 1'b1;
                            n_state      = S_FINISH;
                        end
                        OP_INSERT: begin
                            if (i_sts.idx_at_pos) begin
                                n_state = S_PLACE;
                            end else begin
                                o_cmd.rd_src = 1'b1;
                                n_state      = S_SHIFT;
                            end
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.cap_result = 1'b1;
                if (i_sts.op == OP_REMOVE) begin
                    if (i_sts.has_next) begin
                        o_cmd.rd_src = 1'b1;
                        n_state      = S_SHIFT;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_FINISH;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                if (i_sts.op == OP_INSERT) begin
                    if (i_sts.prev_at_pos) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.rd_src = 1'b1;
                    end
                end else begin
                    if (i_sts.has_next2) begin
                        o_cmd.rd_src = 1'b1;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_FINISH;
                    end
                end
            end
            S_PLACE: begin
                o_cmd.wr_val  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/ial_dp.sv -----
`timescale 1ns / 1ps

module ial_dp import ial_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [STS_W-1:0]         o_status,
    output logic [CNT_OUT_W-1:0]     o_count
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = CW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;

    logic [OP_W-1:0]          r_op;
    logic [AW-1:0]            r_pos;
    logic [AW-1:0]            r_idx;
    logic [DATA_W-1:0]        r_val;
    logic [DATA_W-1:0]        r_result;
    logic [STS_W-1:0]         r_status;
    logic [CW-1:0]            r_count;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_read_value;
    logic [STS_W-1:0]         r_status_out;
    logic [CNT_OUT_W-1:0]     r_count_out;

    logic [CMPW-1:0]  w_pos_c;
    logic [CMPW-1:0]  w_cnt_c;
    logic [STS_W-1:0] w_status;
    logic [AW-1:0]    w_idx_next;
    logic [AW-1:0]    w_src_addr;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;

    // Range and capacity checks on the incoming beat.
    always_comb begin
        w_pos_c  = CMPW'(i_position);
        w_cnt_c  = CMPW'(r_count);
        w_status = ST_OK;
        if (i_operation == OP_INSERT) begin
            if (w_pos_c > w_cnt_c) begin
                w_status = ST_RANGE;
            end else if (w_cnt_c == CMPW'(CAPACITY)) begin
                w_status = ST_FULL;
            end
        end else if (w_pos_c >= w_cnt_c) begin
            w_status = ST_RANGE;
        end
    end

    // Insert walks downwards from the end, remove walks upwards.
    always_comb begin
        w_idx_next = r_idx;
        if (i_cmd.wr_shift) begin
            w_idx_next = (r_op == OP_INSERT) ? AW'(r_idx - 1'b1) : AW'(r_idx + 1'b1);
        end
        w_src_addr = (r_op == OP_INSERT) ? AW'(w_idx_next - 1'b1) : AW'(w_idx_next + 1'b1);
        w_rd_addr  = i_cmd.rd_pos ? r_pos : w_src_addr;
        w_wr_addr  = i_cmd.wr_shift ? r_idx : r_pos;
        w_wr_data  = i_cmd.wr_shift ? r_rd_data : r_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift || i_cmd.wr_val) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_pos || i_cmd.rd_src) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_pos    <= AW'(i_position);
            r_idx    <= (i_operation == OP_INSERT) ? AW'(r_count) : AW'(i_position);
            r_val    <= i_value;
            r_result <= '0;
            r_status <= w_status;
        end else begin
            r_idx <= w_idx_next;
            if (i_cmd.cap_result) begin
                r_result <= r_rd_data;
            end
        end
        if (i_cmd.out_load) begin
            r_read_value <= r_result;
            r_status_out <= r_status;
            r_count_out  <= CNT_OUT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.err         = (r_status != ST_OK);
        o_sts.op          = r_op;
        o_sts.idx_at_pos  = (r_idx == r_pos);
        o_sts.prev_at_pos = (AW'(r_idx - 1'b1) == r_pos);
        o_sts.has_next    = ((IW'(r_idx) + IW'(1)) < IW'(r_count));
        o_sts.has_next2   = ((IW'(r_idx) + IW'(2)) < IW'(r_count));
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status_out;
    assign o_count      = r_count_out;

endmodule

// ----- design/indexed_array_list.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Ordered list of signed 32-bit values held in a simple dual-port store of CAPACITY
// entries, with an element count. Each input beat asks for get, set, insert or
// remove at a list position and produces exactly one result beat carrying the
// value read (get and remove, otherwise zero), a status (ok, index out of range
// or list full) and the element count after the operation. Failed operations
// change nothing. The block works on one operation at a time. The store has
// one write and one registered read port, so an insert or remove moves the
// later entries one per cycle. A finished result sits in an output register,
// so the next beat is taken while that result waits; the block only holds its
// last step when the previous result has still not been taken. The count
// output is the element count reduced to its five bits.
module indexed_array_list import ial_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [STS_W-1:0]         o_status,
    output logic [CNT_OUT_W-1:0]     o_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller sequences each operation: decide, read, shift, place
    // and hand the result over.
    ial_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the store, the count, the walking index and the
    // output register.
    ial_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    // An accepted beat starts work, so the input side closes for at least
    // the following cycle.
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready high straight after an accepted beat")

    // A result is only moved out when the output register can take it.
    `ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, w_sts.out_free, "result loaded over an untaken result")

    // A loaded result is offered on the output in the following cycle.
    `ASSERT_NXT(a_result_offered, i_clk, i_rst_n, w_cmd.out_load, o_out_valid, "loaded result not offered")

    // The count never moves both ways in one cycle.
    `ASSERT_IMP(a_count_one_way, i_clk, i_rst_n, w_cmd.cnt_inc, !w_cmd.cnt_dec, "count raised and lowered together")

endmodule

// ----- tb/tb_indexed_array_list.sv -----
`timescale 1ns / 1ps

module tb_indexed_array_list;
    import ial_pkg::*;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_BEATS     = 450;
    localparam int QUIET_TAIL_BEATS = 60;   // last beats run with no idling at all
    localparam int LONG_HOLD_CYCLES = 120;  // receiver hold-off that backs the block up
    localparam int HOLD_AT_BEAT     = 120;
    localparam int HOLD_SPAN_BEATS  = 40;   // sender offers back to back meanwhile
    localparam int DRAIN_AT_BEAT    = 260;  // sender waits here until every result is in
    localparam int SETTLE_CYCLES    = 40;
    localparam int RUN_LIMIT_NS     = 2_000_000;

    // One result beat as the block presents it.
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STS_W-1:0]         status;
        logic [CNT_OUT_W-1:0]     count;
    } list_result_t;

    // One row of the directed table. Where typed is set the expected result
    // is written into the row; otherwise the shadow list supplies it.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [POS_W-1:0]     pos;
        logic [DATA_W-1:0]    val;
        bit                   typed;
        logic [DATA_W-1:0]    exp_read;
        logic [STS_W-1:0]     exp_status;
        logic [CNT_OUT_W-1:0] exp_count;
    } dir_row_t;

    localparam int DIRECTED_LEN = 29;

    // The directed walk starts on an empty list, probes get, remove and insert
    // past the end, fills the list to capacity with inserts at the front, middle
    // and end, pushes against the full list, removes from both ends and sets past the end.
    localparam dir_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{OP_GET,    5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 5'd0},
        '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 5'd0},
        '{OP_INSERT, 5'd1,  32'h0000_0007, 1'b1, 32'h0000_0000, ST_RANGE, 5'd0},
        '{OP_INSERT, 5'd0,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,    5'd1},
        '{OP_INSERT, 5'd1,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
        '{OP_GET,    5'd0,  32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK,    5'd2},
        '{OP_GET,    5'd1,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK,    5'd2},
        '{OP_SET,    5'd1,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
        '{OP_GET,    5'd2,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 5'd2},
        '{OP_INSERT, 5'd2,  32'h0000_0001, 1'b1, 32'h0000_0000, ST_OK,    5'd3},
        '{OP_INSERT, 5'd0,  32'hAAAA_AAAA, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd2,  32'h5555_5555, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd5,  32'h0000_FFFF, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd1,  32'hFFFF_0000, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd7,  32'h1234_5678, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd3,  32'h0000_0000, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd9,  32'hC001_D00D, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd0,  32'h0F0F_0F0F, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd11, 32'hF0F0_F0F0, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd4,  32'h0000_0002, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd13, 32'h8000_0001, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd6,  32'h7FFF_FFFE, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd15, 32'h3C3C_C3C3, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_INSERT, 5'd16, 32'h0000_0009, 1'b1, 32'h0000_0000, ST_FULL,  5'd16},
        '{OP_GET,    5'd16, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 5'd16},
        '{OP_GET,    5'd15, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_REMOVE, 5'd15, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b0, 32'h0, ST_OK, 5'd0},
        '{OP_SET,    5'd15, 32'h0000_0005, 1'b1, 32'h0000_0000, ST_RANGE, 5'd14}
    };

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_operation  = OP_GET;
    logic [POS_W-1:0]         i_position   = '0;
    logic signed [DATA_W-1:0] i_value      = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic signed [DATA_W-1:0] o_read_value;
    logic [STS_W-1:0]         o_status;
    logic [CNT_OUT_W-1:0]     o_count;

    // Shadow copy of the list, advanced once for every accepted input beat.
    logic signed [DATA_W-1:0] shadow_entries [CAPACITY_DEF];
    int unsigned              shadow_len = 0;

    // Results still owed by the block, oldest first.
    list_result_t owed_results [$];

    // Shared between the sender and the receiver.
    bit hold_off_req = 1'b0;
    bit quiet_tail   = 1'b0;

    int mismatches     = 0;
    int results_seen   = 0;
    int op_tally [4]   = '{0, 0, 0, 0};
    int range_tally    = 0;
    int full_tally     = 0;
    int long_holds     = 0;

    indexed_array_list #(
        .CAPACITY (CAPACITY_DEF)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Applies one operation to the shadow list and returns what the block
    // should report for it. Failed operations leave the list untouched.
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t res;
        int unsigned  k;
        res = '{read_value: '0, status: ST_OK, count: '0};
        if (op == OP_INSERT) begin
            // The range test wins over the full test.
            if (pos > shadow_len) begin
                res.status = ST_RANGE;
            end else if (shadow_len >= CAPACITY_DEF) begin
                res.status = ST_FULL;
            end else begin
                for (k = shadow_len; k > pos; k--) begin
                    shadow_entries[k] = shadow_entries[k-1];
                end
                shadow_entries[pos] = val;
                shadow_len++;
            end
        end else if (pos >= shadow_len) begin
            res.status = ST_RANGE;
        end else if (op == OP_GET) begin
            res.read_value = shadow_entries[pos];
        end else if (op == OP_SET) begin
            shadow_entries[pos] = val;
        end else begin
            res.read_value = shadow_entries[pos];
            for (k = pos; k + 1 < shadow_len; k++) begin
                shadow_entries[k] = shadow_entries[k+1];
            end
            shadow_len--;
        end
        res.count = shadow_len[CNT_OUT_W-1:0];
        return res;
    endfunction

    // Presents one beat and holds it until the block takes it. The valid line
    // is left high so that the next beat can follow without a gap; the caller
    // lowers it when it wants to idle. The expectation is booked at the very
    // edge of acceptance, so the shadow list always matches what was taken.
    task automatic offer_beat(input logic [OP_W-1:0] op,
                              input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val,
                              input bit typed,
                              input list_result_t typed_res);
        list_result_t res;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = apply_list_op(op, pos, val);
        if (typed) begin
            res = typed_res;
        end
        owed_results.push_back(res);
        op_tally[op]++;
        if (res.status == ST_RANGE) range_tally++;
        if (res.status == ST_FULL) full_tally++;
    endtask

    // Sender idling: a random-length burst of empty cycles now and then.
    task automatic sender_gap(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Result checking. Every accepted result beat is matched against the
    // oldest expectation, field by field.
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: read_value %0d, status %0d, count %0d",
                       o_read_value, o_status, o_count);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value, o_read_value);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    mismatches++;
                end
            end
        end
    end

    // Receiver. It stalls in bursts whose density changes as it runs,
    // so there are busy stretches as well as stretches with no stalls at all.
    // Once, on request, it holds off for a long stretch so that the output
    // register fills and the block has to refuse input.
    initial begin
        int stall_level;
        int cycles;
        stall_level = 1;
        cycles      = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                long_holds++;
            end else if (!quiet_tail && stall_level != 0
                         && $urandom_range(0, stall_level == 1 ? 5 : 1) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            cycles++;
            if (cycles % 64 == 0) begin
                stall_level = $urandom_range(0, 2);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        list_result_t typed_res;
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int  target_len;
        int  pick;
        bit  gaps_on;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk.
        for (int r = 0; r < DIRECTED_LEN; r++) begin
            typed_res = '{read_value: DIRECTED_ROWS[r].exp_read,
                          status:     DIRECTED_ROWS[r].exp_status,
                          count:      DIRECTED_ROWS[r].exp_count};
            offer_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].val,
                       DIRECTED_ROWS[r].typed, typed_res);
            sender_gap(1'b1);
        end

        // Random part. Most beats are well formed for the current length of
        // the list, so that the list keeps travelling between empty and full;
        // one in ten takes any position from zero to the capacity. The target length
        // drifts and often sits at the extremes.
        target_len = CAPACITY_DEF;
        gaps_on    = 1'b1;
        typed_res  = '0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 40 == 0) begin
                pick       = $urandom_range(0, 3);
                target_len = (pick == 0) ? 0 :
                             (pick == 1) ? CAPACITY_DEF : $urandom_range(0, CAPACITY_DEF);
            end
            if (n % 25 == 0) begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (n == HOLD_AT_BEAT) begin
                hold_off_req = 1'b1;
            end
            if (n == DRAIN_AT_BEAT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (owed_results.size() != 0) @(posedge i_clk);
            end
            quiet_tail = (n >= RANDOM_BEATS - QUIET_TAIL_BEATS);

            pick = $urandom_range(0, 99);
            if (shadow_len < target_len) begin
                op = (pick < 55) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
                     (pick < 85) ? OP_GET : OP_SET;
            end else if (shadow_len > target_len) begin
                op = (pick < 55) ? OP_REMOVE : (pick < 65) ? OP_INSERT :
                     (pick < 85) ? OP_GET : OP_SET;
            end else begin
                op = pick[1:0];
            end

            if ($urandom_range(0, 9) == 0) begin
                pos = POS_W'($urandom_range(0, CAPACITY_DEF));
            end else if (op == OP_INSERT) begin
                pos = POS_W'($urandom_range(0, shadow_len));
            end else if (shadow_len != 0) begin
                pos = POS_W'($urandom_range(0, shadow_len - 1));
            end else begin
                pos = '0;
            end

            case ($urandom_range(0, 11))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7FFF_FFFF;
                2: val = -32'sd1;
                3: val = '0;
                default: val = $urandom;
            endcase

            offer_beat(op, pos, val, 1'b0, typed_res);
            // While the receiver holds off, beats keep coming back to back.
            sender_gap(gaps_on && !quiet_tail && !hold_off_req
                       && !(n >= HOLD_AT_BEAT && n < HOLD_AT_BEAT + HOLD_SPAN_BEATS));
        end

        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d beats: %0d get, %0d set, %0d insert, %0d remove; %0d long hold-off.",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3], op_tally[OP_GET],
                 op_tally[OP_SET], op_tally[OP_INSERT], op_tally[OP_REMOVE], long_holds);
        $display("Checked %0d results: %0d out of range, %0d list full, %0d mismatching fields.",
                 results_seen, range_tally, full_tally, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/ial_pkg.sv
design/ial_ctrl.sv
design/ial_dp.sv
design/indexed_array_list.sv
tb/tb_indexed_array_list.sv
